// File: src/assert_macros.svh
// Assertion macros shared by the query parameter decoder modules.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: src/qpd_pkg.sv
// Package for the query parameter decoder: result types, phase codes,
// character constants and hex helpers. No dependencies.
package qpd_pkg;

	localparam int MAX_RES     = 3;
	localparam int RES_DEPTH_D = 8;
	localparam int LIMIT_W     = 10;
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 10'd1023;
	localparam logic               REG_VALUE_LIMIT = 1'b0;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2b;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NUL     = 8'h00;

	typedef enum logic [1:0] {
		PH_SEARCH = 2'd0,
		PH_VALUE  = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] value_byte;
		logic       byte_valid;
		logic       value_last;
		logic       key_found;
		logic       value_truncated;
	} res_t;

	typedef struct packed {
		logic [1:0]               n;
		res_t [MAX_RES-1:0]       r;
	} push_t;

	function automatic logic [7:0] key_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h63;
			3'd1: c = 8'h6f;
			3'd2: c = 8'h6d;
			3'd3: c = 8'h6d;
			3'd4: c = 8'h61;
			3'd5: c = 8'h6e;
			3'd6: c = 8'h64;
			default: c = 8'h3d;
		endcase
		return c;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] v;
		if (c >= 8'h61) begin
			v = 4'(c - 8'h57);
		end else if (c >= 8'h41) begin
			v = 4'(c - 8'h37);
		end else begin
			v = 4'(c - 8'h30);
		end
		return v;
	endfunction

endpackage

// File: src/qpd_cfg.sv
// Configuration register bank of the query parameter decoder.
// APB-style write and read of value_limit; depends on qpd_pkg.
module qpd_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [qpd_pkg::ADDR_W-1:0] paddr,
	input  logic [qpd_pkg::DATA_W-1:0] pwdata,
	output logic [qpd_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output logic [qpd_pkg::LIMIT_W-1:0] value_limit
);
	import qpd_pkg::*;

	logic [LIMIT_W-1:0] value_limit_q;
	logic               reg_idx;

	assign reg_idx = paddr[ADDR_W-1];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && reg_idx == REG_VALUE_LIMIT) begin
			value_limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_VALUE_LIMIT) begin
			prdata = {{(DATA_W-LIMIT_W){1'b0}}, value_limit_q};
		end
	end

	assign value_limit = value_limit_q;

endmodule

// File: src/qpd_decode.sv
// Input register, key matcher and percent decoder of the query decoder.
// Produces up to three results per request; depends on qpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qpd_decode (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [7:0]                  query_byte,
	input  logic                        query_last,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [qpd_pkg::LIMIT_W-1:0] value_limit,
	input  logic                        room,
	output qpd_pkg::push_t              push
);
	import qpd_pkg::*;

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               end_s1;

	phase_t             phase_q;
	logic [2:0]         key_pos_q;
	logic [1:0]         held_cnt_q;
	logic [7:0]         held_dig_q;
	logic [LIMIT_W-1:0] emitted_q;
	logic               dropped_q;

	phase_t             ph_n;
	logic [2:0]         pos_n;
	logic [1:0]         hc_n;
	logic [7:0]         hd_n;
	logic [LIMIT_W-1:0] em_n;
	logic               dr_n;
	push_t              p;

	logic step;
	logic load;

	assign step     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign load     = in_valid && !in_stall;

	always_comb begin
		logic [7:0] cb [MAX_RES];
		logic [1:0] cn;
		logic [1:0] ne;
		logic       alive;
		logic       ended;
		logic       nf;
		logic       do_plain;

		ph_n     = phase_q;
		pos_n    = key_pos_q;
		hc_n     = held_cnt_q;
		hd_n     = held_dig_q;
		em_n     = emitted_q;
		dr_n     = dropped_q;
		p        = '0;
		cb[0]    = CH_NUL;
		cb[1]    = CH_NUL;
		cb[2]    = CH_NUL;
		cn       = 2'd0;
		ne       = 2'd0;
		alive    = 1'b1;
		ended    = 1'b0;
		nf       = 1'b0;
		do_plain = 1'b0;

		case (phase_q)
			PH_SEARCH: begin
				if (byte_s1 == key_char(key_pos_q)) begin
					if (key_pos_q == 3'd7) begin
						ph_n  = PH_VALUE;
						pos_n = 3'd0;
					end else begin
						pos_n = key_pos_q + 3'd1;
					end
				end else begin
					pos_n = (byte_s1 == key_char(3'd0)) ? 3'd1 : 3'd0;
				end
				if (end_s1) begin
					if (ph_n == PH_SEARCH) begin
						nf = 1'b1;
					end else begin
						ended = 1'b1;
					end
				end
			end
			PH_VALUE: begin
				case (held_cnt_q)
					2'd1: begin
						if (is_hex(byte_s1)) begin
							hd_n = byte_s1;
							hc_n = 2'd2;
						end else begin
							hc_n     = 2'd0;
							cb[cn]   = CH_PERCENT;
							cn       = cn + 2'd1;
							do_plain = 1'b1;
						end
					end
					2'd2: begin
						hc_n = 2'd0;
						if (is_hex(byte_s1)) begin
							cb[cn] = {hex_val(held_dig_q), hex_val(byte_s1)};
							cn     = cn + 2'd1;
						end else begin
							cb[cn]   = CH_PERCENT;
							cn       = cn + 2'd1;
							cb[cn]   = held_dig_q;
							cn       = cn + 2'd1;
							do_plain = 1'b1;
						end
					end
					default: begin
						hc_n     = 2'd0;
						do_plain = 1'b1;
					end
				endcase
				if (do_plain) begin
					if (byte_s1 == CH_PERCENT) begin
						hc_n = 2'd1;
					end else if (byte_s1 == CH_PLUS) begin
						cb[cn] = CH_SPACE;
						cn     = cn + 2'd1;
					end else if (byte_s1 == CH_AMP) begin
						cb[cn] = CH_NUL;
						cn     = cn + 2'd1;
					end else begin
						cb[cn] = byte_s1;
						cn     = cn + 2'd1;
					end
				end
				// flush an open escape literally at query end
				if (end_s1) begin
					if (hc_n != 2'd0) begin
						cb[cn] = CH_PERCENT;
						cn     = cn + 2'd1;
					end
					if (hc_n == 2'd2) begin
						cb[cn] = hd_n;
						cn     = cn + 2'd1;
					end
					hc_n = 2'd0;
				end
				for (int i = 0; i < MAX_RES; i++) begin
					if (i < int'(cn) && alive) begin
						if (cb[i] == CH_NUL) begin
							alive = 1'b0;
							ended = 1'b1;
						end else if (em_n < value_limit) begin
							p.r[ne] = '{value_byte: cb[i], byte_valid: 1'b1,
								value_last: 1'b0, key_found: 1'b1, value_truncated: 1'b0};
							ne   = ne + 2'd1;
							em_n = em_n + 10'd1;
						end else begin
							dr_n = 1'b1;
						end
					end
				end
				if (end_s1 && alive) begin
					ended = 1'b1;
				end
				if (ended) begin
					ph_n = PH_DONE;
					hc_n = 2'd0;
					hd_n = 8'd0;
				end
			end
			default: begin
			end
		endcase

		if (nf) begin
			p.r[0] = '{value_byte: 8'd0, byte_valid: 1'b0, value_last: 1'b1,
				key_found: 1'b0, value_truncated: 1'b0};
			ne = 2'd1;
		end
		if (ended) begin
			if (ne != 2'd0) begin
				p.r[ne-2'd1].value_last      = 1'b1;
				p.r[ne-2'd1].value_truncated = dr_n;
			end else begin
				p.r[0] = '{value_byte: 8'd0, byte_valid: 1'b0, value_last: 1'b1,
					key_found: 1'b1, value_truncated: dr_n};
				ne = 2'd1;
			end
		end
		p.n = step ? ne : 2'd0;
	end

	assign push = p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			phase_q    <= PH_SEARCH;
			key_pos_q  <= 3'd0;
			held_cnt_q <= 2'd0;
			held_dig_q <= 8'd0;
			emitted_q  <= '0;
			dropped_q  <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				if (end_s1) begin
					phase_q    <= PH_SEARCH;
					key_pos_q  <= 3'd0;
					held_cnt_q <= 2'd0;
					held_dig_q <= 8'd0;
					emitted_q  <= '0;
					dropped_q  <= 1'b0;
				end else begin
					phase_q    <= ph_n;
					key_pos_q  <= pos_n;
					held_cnt_q <= hc_n;
					held_dig_q <= hd_n;
					emitted_q  <= em_n;
					dropped_q  <= dr_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= query_byte;
			end_s1  <= query_last;
		end
	end

	`ASSERT_CLK(a_hold_search, phase_q == PH_SEARCH |-> held_cnt_q == 2'd0, "escape held while searching")
	`ASSERT_CLK(a_stall_hold, in_stall |=> valid_s1 && $stable(phase_q) && $stable(emitted_q), "state moved while stalled")
	`ASSERT_CLK(a_one_last, $countones({p.r[0].value_last, p.r[1].value_last, p.r[2].value_last}) <= 1, "several final results in one request")
	`ASSERT_NEVER(a_emit_over, step && emitted_q > value_limit && em_n != emitted_q, "byte emitted beyond limit")

endmodule

// File: src/qpd_fifo.sv
// Result queue of the query decoder: takes up to three results a cycle,
// presents one at a time on the output channel. Depends on qpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qpd_fifo #(
	parameter int DEPTH = qpd_pkg::RES_DEPTH_D
) (
	input  logic           clk,
	input  logic           arst_n,
	input  qpd_pkg::push_t push,
	output logic           room,
	output qpd_pkg::res_t  head,
	output logic           out_valid,
	input  logic           out_stall
);
	import qpd_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	res_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic [PTR_W-1:0] wr_idx [MAX_RES];
	logic [PTR_W-1:0] wr_ptr_n;
	logic [PTR_W-1:0] rd_ptr_n;
	logic             pop;

	function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
		input logic [1:0] off);
		logic [PTR_W:0] s;
		s = {1'b0, base} + (PTR_W+1)'(off);
		if (s >= (PTR_W+1)'(DEPTH)) begin
			s = s - (PTR_W+1)'(DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

	assign out_valid = count_q != '0;
	assign pop       = out_valid && !out_stall;
	assign room      = count_q <= CNT_W'(DEPTH - MAX_RES);
	assign head      = mem_q[rd_ptr_q];

	always_comb begin
		for (int i = 0; i < MAX_RES; i++) begin
			wr_idx[i] = wrap_add(wr_ptr_q, 2'(i));
		end
		wr_ptr_n = wrap_add(wr_ptr_q, push.n);
		rd_ptr_n = wrap_add(rd_ptr_q, 2'd1);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (i < int'(push.n)) begin
				mem_q[wr_idx[i]] <= push.r[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_n;
			if (pop) begin
				rd_ptr_q <= rd_ptr_n;
			end
			count_q <= count_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

	`ASSERT_CLK(a_no_overfill, count_q <= CNT_W'(DEPTH), "result queue overfilled")
	`ASSERT_CLK(a_push_room, push.n != 2'd0 |-> room, "results written without room")
	`ASSERT_CLK(a_pop_count, pop && push.n == 2'd0 |=> count_q == $past(count_q) - CNT_W'(1), "queue count lost a pop")

endmodule

// File: src/query_param_percent_decoder.sv
// Query parameter percent decoder: finds "command=" in a query string
// and streams the URL-decoded value. Built from qpd_cfg, qpd_decode and qpd_fifo.
//
// Usage:
//   Input channel: one query byte per request (query_byte, query_last on the
//   final byte), in_valid / in_stall. Output channel: one decoded result per
//   request (value_byte, byte_valid, value_last, key_found, value_truncated),
//   out_valid / out_stall. The APB port holds value_limit at byte address 0.
//   A taken byte is held in the input register and decoded from there; its
//   results are written into the result queue once it has room, then shown on the output.
//   Throughput: one byte per cycle. Each byte gives zero to three results; they
//   enter a result queue of RES_DEPTH entries, which drains one per cycle.
//   The input stalls only while that queue lacks room for three results, so
//   the sustained rate is set by the output drain of one result per cycle.
//   A stalled receiver fills the queue, then backs the stall onto the input.
//   Reset clears the queue, the matcher and decoder state, and sets
//   value_limit to 1023. State returns to its reset values after each
//   final query byte.
module query_param_percent_decoder #(
	parameter int RES_DEPTH = qpd_pkg::RES_DEPTH_D
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [qpd_pkg::ADDR_W-1:0] paddr,
	input  logic [qpd_pkg::DATA_W-1:0] pwdata,
	output logic [qpd_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic [7:0]                 query_byte,
	input  logic                       query_last,
	input  logic                       in_valid,
	output logic                       in_stall,
	output logic [7:0]                 value_byte,
	output logic                       byte_valid,
	output logic                       value_last,
	output logic                       key_found,
	output logic                       value_truncated,
	output logic                       out_valid,
	input  logic                       out_stall
);
	import qpd_pkg::*;

	logic [LIMIT_W-1:0] value_limit;
	logic               room;
	push_t              push;
	res_t               head;

	qpd_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.value_limit (value_limit)
	);

	qpd_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.query_byte  (query_byte),
		.query_last  (query_last),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.value_limit (value_limit),
		.room        (room),
		.push        (push)
	);

	qpd_fifo #(
		.DEPTH (RES_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.head      (head),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

	assign value_byte      = head.value_byte;
	assign byte_valid      = head.byte_valid;
	assign value_last      = head.value_last;
	assign key_found       = head.key_found;
	assign value_truncated = head.value_truncated;

endmodule

// File: tb/decoded_value_checker.sv
`timescale 1ns / 100ps
// Checker for query_param_percent_decoder: tracks value_limit writes on the APB port,
// predicts the decoded value results of every accepted query byte and compares
// them with the output channel. Depends on qpd_pkg.
module decoded_value_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [qpd_pkg::ADDR_W-1:0] paddr,
	input  logic [qpd_pkg::DATA_W-1:0] pwdata,
	input  logic [7:0]                 query_byte,
	input  logic                       query_last,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [7:0]                 value_byte,
	input  logic                       byte_valid,
	input  logic                       value_last,
	input  logic                       key_found,
	input  logic                       value_truncated,
	input  logic                       out_valid,
	input  logic                       out_stall,
	output int                         mismatches,
	output int                         outstanding
);
	import qpd_pkg::*;

	localparam logic [ADDR_W-1:0] LIMIT_ADDR = ADDR_W'(4 * REG_VALUE_LIMIT);
	localparam logic [63:0]       KEY_TEXT   = "command=";
	localparam int                KEY_LEN    = 8;

	logic [LIMIT_W-1:0] limit;
	logic [3:0]         key_pos;
	phase_t             phase;
	logic [1:0]         esc_count;
	logic [7:0]         esc_digit;
	logic [LIMIT_W-1:0] emitted;
	logic               dropped;
	logic               value_done;
	res_t               step_results[$];
	res_t               expected_results[$];

	function automatic logic hex_digit(input logic [7:0] c);
		return c inside {["0":"9"], ["a":"f"], ["A":"F"]};
	endfunction

	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		if (c <= "9") begin
			return c[3:0];
		end
		return c[3:0] + 4'd9;
	endfunction

	task automatic add_result(input logic [7:0] b, input logic v, input logic l,
			input logic f, input logic t);
		res_t r;
		r.value_byte      = b;
		r.byte_valid      = v;
		r.value_last      = l;
		r.key_found       = f;
		r.value_truncated = t;
		if (step_results.size() < MAX_RES) begin
			step_results.push_back(r);
		end
	endtask

	task automatic finish_value();
		phase      = PH_DONE;
		esc_count  = 2'd0;
		esc_digit  = 8'd0;
		value_done = 1'b1;
	endtask

	task automatic clear_query();
		key_pos   = 4'd0;
		phase     = PH_SEARCH;
		esc_count = 2'd0;
		esc_digit = 8'd0;
		emitted   = '0;
		dropped   = 1'b0;
	endtask

	task automatic emit(input logic [7:0] b);
		if (phase != PH_VALUE) begin
			return;
		end
		if (b == CH_NUL) begin
			finish_value();
		end else if (emitted < limit) begin
			add_result(b, 1'b1, 1'b0, 1'b1, 1'b0);
			emitted = emitted + 1'b1;
		end else begin
			dropped = 1'b1;
		end
	endtask

	task automatic literal(input logic [7:0] b);
		if (phase != PH_VALUE) begin
			return;
		end
		if (b == CH_PERCENT) begin
			esc_count = 2'd1;
		end else if (b == CH_PLUS) begin
			emit(CH_SPACE);
		end else if (b == CH_AMP) begin
			finish_value();
		end else begin
			emit(b);
		end
	endtask

	task automatic value_in(input logic [7:0] b);
		logic [7:0] d;
		case (esc_count)
			2'd1: begin
				if (hex_digit(b)) begin
					esc_digit = b;
					esc_count = 2'd2;
					return;
				end
				esc_count = 2'd0;
				emit(CH_PERCENT);
			end
			2'd2: begin
				d = esc_digit;
				esc_count = 2'd0;
				if (hex_digit(b)) begin
					emit({nibble_of(d), nibble_of(b)});
					return;
				end
				emit(CH_PERCENT);
				emit(d);
			end
			default: esc_count = 2'd0;
		endcase
		literal(b);
	endtask

	task automatic search(input logic [7:0] b);
		int pos;
		pos = key_pos;
		if (pos >= KEY_LEN) begin
			pos = 0;
		end
		if (b == KEY_TEXT[63 - 8 * pos -: 8]) begin
			pos++;
			if (pos == KEY_LEN) begin
				phase = PH_VALUE;
				pos = 0;
			end
		end else begin
			pos = (b == KEY_TEXT[63 -: 8]) ? 1 : 0;
		end
		key_pos = 4'(pos);
	endtask

	task automatic decode_query_byte(input logic [7:0] b, input logic last);
		logic [1:0] held;
		logic [7:0] d;
		res_t       tail;
		step_results.delete();
		value_done = 1'b0;
		if (phase == PH_SEARCH) begin
			search(b);
		end else if (phase == PH_VALUE) begin
			value_in(b);
		end
		if (last) begin
			if (phase == PH_SEARCH) begin
				add_result(8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
			end else if (phase == PH_VALUE) begin
				held = esc_count;
				d = esc_digit;
				esc_count = 2'd0;
				if (held >= 2'd1) begin
					emit(CH_PERCENT);
				end
				if (held == 2'd2) begin
					emit(d);
				end
				finish_value();
			end
		end
		if (value_done) begin
			if (step_results.size() > 0) begin
				tail = step_results[step_results.size() - 1];
				tail.value_last = 1'b1;
				tail.value_truncated = dropped;
				step_results[step_results.size() - 1] = tail;
			end else begin
				add_result(8'd0, 1'b0, 1'b1, 1'b1, dropped);
			end
		end
		if (last) begin
			clear_query();
		end
		foreach (step_results[i]) begin
			expected_results.push_back(step_results[i]);
		end
	endtask

	task automatic note_failure(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s", $time, msg);
		end
	endtask

	task automatic check_result();
		res_t got;
		res_t want;
		got = '{value_byte, byte_valid, value_last, key_found, value_truncated};
		if (expected_results.size() == 0) begin
			note_failure($sformatf("unexpected result byte=%02h valid=%0b last=%0b found=%0b trunc=%0b",
				got.value_byte, got.byte_valid, got.value_last, got.key_found,
				got.value_truncated));
		end else begin
			want = expected_results.pop_front();
			if (got !== want) begin
				note_failure($sformatf({"mismatch expected byte=%02h valid=%0b last=%0b found=%0b ",
					"trunc=%0b, got byte=%02h valid=%0b last=%0b found=%0b trunc=%0b"},
					want.value_byte, want.byte_valid, want.value_last, want.key_found,
					want.value_truncated, got.value_byte, got.byte_valid, got.value_last,
					got.key_found, got.value_truncated));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_query();
			limit = LIMIT_RESET;
			expected_results.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				check_result();
			end
			if (in_valid && !in_stall) begin
				decode_query_byte(query_byte, query_last);
			end
			if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR) begin
				limit = pwdata[LIMIT_W-1:0];
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the query_param_percent_decoder testbench: clock, reset, APB writes of
// value_limit and query stimulus with random idling; decoded_value_checker does
// the checking. Depends on qpd_pkg, query_param_percent_decoder and decoded_value_checker.
module tb_top;
	import qpd_pkg::*;

	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 60;
	localparam int PHASE_ITEMS = 60;
	localparam int SETTLE      = 8;
	localparam logic [ADDR_W-1:0] LIMIT_ADDR = ADDR_W'(4 * REG_VALUE_LIMIT);

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic [7:0]        query_byte;
	logic              query_last;
	logic              in_valid;
	logic              in_stall;
	logic [7:0]        value_byte;
	logic              byte_valid;
	logic              value_last;
	logic              key_found;
	logic              value_truncated;
	logic              out_valid;
	logic              out_stall;

	int         mismatches;
	int         outstanding;
	int         idle_cycles;
	int         sent_requests;
	bit         tx_no_gap;
	bit         rx_no_stall;
	bit         hold_off_req;
	logic [7:0] query_text[$];

	query_param_percent_decoder uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.query_byte      (query_byte),
		.query_last      (query_last),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.value_byte      (value_byte),
		.byte_valid      (byte_valid),
		.value_last      (value_last),
		.key_found       (key_found),
		.value_truncated (value_truncated),
		.out_valid       (out_valid),
		.out_stall       (out_stall)
	);

	decoded_value_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.query_byte      (query_byte),
		.query_last      (query_last),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.value_byte      (value_byte),
		.byte_valid      (byte_valid),
		.value_last      (value_last),
		.key_found       (key_found),
		.value_truncated (value_truncated),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.mismatches      (mismatches),
		.outstanding     (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_request(input logic [7:0] b, input logic last);
		int gap;
		gap = tx_no_gap ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		query_byte <= b;
		query_last <= last;
		do @(posedge clk); while (in_stall);
		sent_requests++;
	endtask

	task automatic send_query();
		foreach (query_text[i]) begin
			send_request(query_text[i], i == query_text.size() - 1);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= LIMIT_ADDR;
		pwdata  <= DATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			query_text.push_back(s[i]);
		end
	endtask

	function automatic logic [7:0] hex_char();
		string digits;
		digits = "0123456789abcdefABCDEF";
		return digits[$urandom_range(0, 21)];
	endfunction

	function automatic logic [7:0] lower_char();
		return 8'("a" + $urandom_range(0, 25));
	endfunction

	task automatic add_noise();
		case ($urandom_range(0, 5))
			0: query_text.push_back(lower_char());
			1: push_text("comm");
			2: push_text("c");
			3: push_text("x=1&");
			4: push_text("command");
			default: query_text.push_back(8'($urandom_range(1, 255)));
		endcase
	endtask

	task automatic add_value_piece();
		case ($urandom_range(0, 11))
			0, 1: query_text.push_back(lower_char());
			2: query_text.push_back(8'("0" + $urandom_range(0, 9)));
			3: query_text.push_back(CH_PLUS);
			4: begin
				query_text.push_back(CH_PERCENT);
				query_text.push_back(hex_char());
				query_text.push_back(hex_char());
			end
			5: push_text($urandom_range(0, 1) ? "%00" : "%26");
			6: begin
				query_text.push_back(CH_PERCENT);
				case ($urandom_range(0, 3))
					0: query_text.push_back(CH_PERCENT);
					1: query_text.push_back(CH_PLUS);
					2: query_text.push_back(CH_AMP);
					default: query_text.push_back(8'("g" + $urandom_range(0, 19)));
				endcase
			end
			7: begin
				query_text.push_back(CH_PERCENT);
				query_text.push_back(hex_char());
				query_text.push_back($urandom_range(0, 1) ? 8'("z") : CH_AMP);
			end
			8: push_text("&x=y");
			9: query_text.push_back(8'($urandom_range(1, 255)));
			10: begin
				query_text.push_back(CH_PERCENT);
				if ($urandom_range(0, 1)) begin
					query_text.push_back(hex_char());
				end
			end
			default: push_text($urandom_range(0, 1) ? "=" : "command=");
		endcase
	endtask

	task automatic build_query();
		int kind;
		kind = $urandom_range(0, 9);
		query_text.delete();
		if (kind == 0) begin
			repeat ($urandom_range(1, 12)) query_text.push_back(8'($urandom_range(1, 255)));
		end else begin
			repeat ($urandom_range(0, 3)) add_noise();
			if (kind != 1) begin
				push_text("command=");
				repeat ($urandom_range(0, 6)) add_value_piece();
			end
		end
		if (query_text.size() == 0) begin
			push_text("z");
		end
	endtask

	initial begin
		int wait_cycles;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				wait_cycles = HOLD_CYCLES;
				hold_off_req <= 1'b0;
			end else if (rx_no_stall) begin
				wait_cycles = 0;
			end else begin
				wait_cycles = $urandom_range(0, 9);
			end
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int                 phase_start;
		logic [LIMIT_W-1:0] lim;
		arst_n     <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		in_valid   <= 1'b0;
		query_byte <= 8'd0;
		query_last <= 1'b0;
		idle_cycles   = 0;
		sent_requests = 0;
		tx_no_gap     = 1'b0;
		rx_no_stall  <= 1'b0;
		hold_off_req <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		query_text.delete();
		query_text.push_back(8'hff);
		send_query();
		query_text.delete();
		push_text("command=");
		query_text.push_back(8'h01);
		push_text("%4a+%Zx%3");
		send_query();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: lim = '0;
				1: lim = 10'd1;
				2: lim = 10'd3;
				3: lim = 10'($urandom_range(2, 15));
				4: lim = LIMIT_RESET;
				default: lim = 10'($urandom_range(4, 20));
			endcase
			drain();
			write_limit(lim);
			tx_no_gap = (p == 2 || p == 3);
			rx_no_stall <= (p == 2);
			hold_off_req <= (p == 3);
			phase_start = sent_requests;
			while (sent_requests - phase_start < PHASE_ITEMS) begin
				build_query();
				send_query();
				if ($urandom_range(0, 7) == 0) begin
					drain();
				end
			end
		end
		drain();

		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
